// ----- src/niqb_pkg.sv -----
// ---------------------------------------------------------------------------
// niqb_pkg
// Shared constants and types for the normalized inverse-quadratic blur core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package niqb_pkg;

   localparam int MAX_ROWS    = 512;
   localparam int MAX_COLUMNS = 512;
   localparam int ROW_W       = $clog2(MAX_ROWS);
   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int ADDR_W      = ROW_W + COL_W;
   localparam int DEPTH       = MAX_ROWS * MAX_COLUMNS;
   localparam int PIX_W       = 32;

   localparam int REM_W       = 33;
   localparam int BITS_W      = 64;
   localparam int STEP_W      = 6;

   localparam logic [STEP_W-1:0] WEIGHT_STEPS = 6'd16;
   localparam logic [STEP_W-1:0] FINAL_STEPS  = 6'd33;
   localparam logic [15:0]       CENTER_WEIGHT = 16'hFFFF;

   localparam logic [1:0] REG_ROWS    = 2'd0;
   localparam logic [1:0] REG_COLUMNS = 2'd1;
   localparam logic [1:0] REG_WINDOW  = 2'd2;
   localparam logic [1:0] REG_AMOUNT  = 2'd3;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_READ  = 1'b1;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_TAP   = 6'b000010,
      ST_WAIT  = 6'b000100,
      ST_FINAL = 6'b001000,
      ST_FWAIT = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [STEP_W-1:0]    steps;
      logic [REM_W-1:0]     rem_init;
      logic [BITS_W-1:0]    bits_init;
      logic [REM_W-1:0]     divisor;
   } div_req_type;

endpackage
`default_nettype wire

// ----- src/niqb_ram.sv -----
// ---------------------------------------------------------------------------
// niqb_ram
// Generic single-write, single-read memory with a registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module niqb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_address,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic                     read_enable,
   input  wire logic [$clog2(DEPTH)-1:0] read_address,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule
`default_nettype wire

// ----- src/niqb_div.sv -----
// ---------------------------------------------------------------------------
// niqb_div
// Restoring divider producing one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module niqb_div
   import niqb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output logic             busy,
   output logic [REM_W-1:0] quotient
);

   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [BITS_W-1:0] bits_ff, bits_in;
   logic [REM_W-1:0]  divisor_ff, divisor_in;
   logic [STEP_W-1:0] count_ff, count_in;
   logic              busy_ff, busy_in;
   logic [REM_W:0]    trial;
   logic [REM_W:0]    diff;
   logic              take;

   always_comb begin
      trial      = {rem_ff, bits_ff[BITS_W-1]};
      diff       = trial - {1'b0, divisor_ff};
      take       = !diff[REM_W];
      rem_in     = rem_ff;
      bits_in    = bits_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      busy_in    = busy_ff;
      if (req.start) begin
         rem_in     = req.rem_init;
         bits_in    = req.bits_init;
         divisor_in = req.divisor;
         count_in   = req.steps;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in   = take ? diff[REM_W-1:0] : trial[REM_W-1:0];
         bits_in  = {bits_ff[BITS_W-2:0], take};
         count_in = count_ff - 1'b1;
         busy_in  = (count_ff != 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      bits_ff    <= bits_in;
      divisor_ff <= divisor_in;
   end

   assign busy     = busy_ff;
   assign quotient = bits_ff[REM_W-1:0];

endmodule
`default_nettype wire

// ----- src/normalized_inverse_quadratic_blur_core.sv -----
// ---------------------------------------------------------------------------
// normalized_inverse_quadratic_blur_core
// Image store with a normalized inverse-quadratic blur read-out.
//
//   Channel  Direction  Handshake        Carries
//   req      in         valid / stall    action, row, column, pixel_in
//   rsp      out        valid / stall    blurred_value, coordinate_valid
//   csr      in         write_enable     index, write_data
//
// A write is stored without leaving the idle state. A read walks the window
// one tap at a time; a tap in the image off the center costs one store read
// and a weight division, the center tap one store read and a tap outside the
// image neither. A final division then normalizes the sum. Reset is
// synchronous; the image store is not cleared. The core takes a new
// transaction while a finished result waits under rsp_stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module normalized_inverse_quadratic_blur_core
   import niqb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_action,
   input  wire logic [ROW_W-1:0]  req_row,
   input  wire logic [COL_W-1:0]  req_column,
   input  wire logic [PIX_W-1:0]  req_pixel_in,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [PIX_W-1:0]       rsp_blurred_value,
   output logic                   rsp_coordinate_valid,
   input  wire logic              csr_write_enable,
   input  wire logic [1:0]        csr_index,
   input  wire logic [15:0]       csr_write_data
);

   state_type state_ff, state_in;

   logic [9:0]  rows_ff, cols_ff;
   logic [3:0]  window_ff;
   logic [15:0] amount_ff;

   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [31:0]      a2_ff, a2_in;
   logic [3:0]       di_ff, di_in, dj_ff, dj_in;
   logic [63:0]      sum_ff, sum_in;
   logic [23:0]      total_ff, total_in;
   logic             center_ff, center_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_value_ff, rsp_value_in;
   logic             rsp_cv_ff, rsp_cv_in;
   logic [PIX_W-1:0] res_ff, res_in;
   logic             res_cv_ff, res_cv_in;

   logic [9:0]  nr, nc;
   logic [2:0]  half;
   logic [3:0]  neg_half;
   logic        req_fire, req_inside;
   logic [10:0] r_tap, c_tap;
   logic        tap_inside;
   logic [2:0]  abs_di, abs_dj;
   logic [6:0]  d2;
   logic [32:0] den;
   logic [48:0] wdividend;
   logic [63:0] fdividend;
   logic [15:0] weight;
   logic        last_dj, last_di;

   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [PIX_W-1:0]  ram_rdata;

   div_req_type      dreq;
   logic             div_busy;
   logic [REM_W-1:0] div_quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff   <= 10'd512;
         cols_ff   <= 10'd512;
         window_ff <= 4'd3;
         amount_ff <= 16'd256;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_ROWS:    rows_ff   <= csr_write_data[9:0];
            REG_COLUMNS: cols_ff   <= csr_write_data[9:0];
            REG_WINDOW:  window_ff <= csr_write_data[3:0];
            REG_AMOUNT:  amount_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      nr         = (rows_ff > 10'(MAX_ROWS)) ? 10'(MAX_ROWS) : rows_ff;
      nc         = (cols_ff > 10'(MAX_COLUMNS)) ? 10'(MAX_COLUMNS) : cols_ff;
      half       = window_ff[3:1];
      neg_half   = 4'd0 - {1'b0, half};
      req_fire   = req_valid && !req_stall;
      req_inside = ({1'b0, req_row} < nr) && ({1'b0, req_column} < nc);

      r_tap      = {2'b00, row_ff} + {{7{di_ff[3]}}, di_ff};
      c_tap      = {2'b00, col_ff} + {{7{dj_ff[3]}}, dj_ff};
      tap_inside = !r_tap[10] && (r_tap[9:0] < nr) && !c_tap[10] && (c_tap[9:0] < nc);
      abs_di     = di_ff[3] ? 3'(4'd0 - di_ff) : di_ff[2:0];
      abs_dj     = dj_ff[3] ? 3'(4'd0 - dj_ff) : dj_ff[2:0];
      d2         = ({4'd0, abs_di} * {4'd0, abs_di}) + ({4'd0, abs_dj} * {4'd0, abs_dj});
      den        = {1'b0, a2_ff} + {10'd0, d2, 16'd0};
      wdividend  = {1'b0, a2_ff, 16'd0} + {17'd0, den[32:1]};
      fdividend  = sum_ff + {41'd0, total_ff[23:1]};
      weight     = center_ff ? CENTER_WEIGHT : div_quo[15:0];
      last_dj    = (dj_ff == {1'b0, half});
      last_di    = (di_ff == {1'b0, half});
   end

   assign ram_we    = req_fire && (req_action == ACTION_WRITE) && req_inside;
   assign ram_waddr = {req_row, req_column};
   assign ram_re    = (state_ff == ST_TAP) && tap_inside;
   assign ram_raddr = {r_tap[ROW_W-1:0], c_tap[COL_W-1:0]};

   niqb_ram #(
      .WIDTH(PIX_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock(clock),
      .write_enable(ram_we),
      .write_address(ram_waddr),
      .write_data(req_pixel_in),
      .read_enable(ram_re),
      .read_address(ram_raddr),
      .read_data(ram_rdata)
   );

   always_comb begin
      dreq.start     = 1'b0;
      dreq.steps     = WEIGHT_STEPS;
      dreq.rem_init  = wdividend[48:16];
      dreq.bits_init = {wdividend[15:0], 48'd0};
      dreq.divisor   = den;
      if (state_ff == ST_FINAL) begin
         dreq.start     = 1'b1;
         dreq.steps     = FINAL_STEPS;
         dreq.rem_init  = {2'b00, fdividend[63:33]};
         dreq.bits_init = {fdividend[32:0], 31'd0};
         dreq.divisor   = {9'd0, total_ff};
      end else if ((state_ff == ST_TAP) && tap_inside && (d2 != 7'd0)) begin
         dreq.start = 1'b1;
      end
   end

   niqb_div u_div (
      .clock(clock),
      .reset(reset),
      .req(dreq),
      .busy(div_busy),
      .quotient(div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      a2_in        = a2_ff;
      di_in        = di_ff;
      dj_in        = dj_ff;
      sum_in       = sum_ff;
      total_in     = total_ff;
      center_in    = center_ff;
      res_in       = res_ff;
      res_cv_in    = res_cv_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_cv_in    = rsp_cv_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_action == ACTION_READ)) begin
               row_in   = req_row;
               col_in   = req_column;
               a2_in    = {16'd0, amount_ff} * {16'd0, amount_ff};
               di_in    = neg_half;
               dj_in    = neg_half;
               sum_in   = '0;
               total_in = '0;
               if (req_inside) begin
                  state_in = ST_TAP;
               end else begin
                  res_in    = '0;
                  res_cv_in = 1'b0;
                  state_in  = ST_DONE;
               end
            end
         end
         ST_TAP: begin
            if (tap_inside) begin
               center_in = (d2 == 7'd0);
               state_in  = ST_WAIT;
            end else if (last_dj) begin
               dj_in    = neg_half;
               di_in    = di_ff + 4'd1;
               state_in = last_di ? ST_FINAL : ST_TAP;
            end else begin
               dj_in = dj_ff + 4'd1;
            end
         end
         ST_WAIT: begin
            if (!div_busy) begin
               sum_in   = sum_ff + {16'd0, {16'd0, ram_rdata} * {32'd0, weight}};
               total_in = total_ff + {8'd0, weight};
               if (last_dj) begin
                  dj_in    = neg_half;
                  di_in    = di_ff + 4'd1;
                  state_in = last_di ? ST_FINAL : ST_TAP;
               end else begin
                  dj_in    = dj_ff + 4'd1;
                  state_in = ST_TAP;
               end
            end
         end
         ST_FINAL: begin
            state_in = ST_FWAIT;
         end
         ST_FWAIT: begin
            if (!div_busy) begin
               res_in    = div_quo[32] ? 32'hFFFF_FFFF : div_quo[31:0];
               res_cv_in = 1'b1;
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               rsp_cv_in    = res_cv_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff       <= row_in;
      col_ff       <= col_in;
      a2_ff        <= a2_in;
      di_ff        <= di_in;
      dj_ff        <= dj_in;
      sum_ff       <= sum_in;
      total_ff     <= total_in;
      center_ff    <= center_in;
      res_ff       <= res_in;
      res_cv_ff    <= res_cv_in;
      rsp_value_ff <= rsp_value_in;
      rsp_cv_ff    <= rsp_cv_in;
   end

   assign req_stall            = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_blurred_value    = rsp_value_ff;
   assign rsp_coordinate_valid = rsp_cv_ff;

endmodule
`default_nettype wire

// ----- src/niqb_checker.sv -----
// ---------------------------------------------------------------------------
// niqb_checker
// Port-level checks for the blur core, bound to its top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module niqb_checker
   import niqb_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             req_action,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire logic [PIX_W-1:0] rsp_blurred_value,
   input wire logic             rsp_coordinate_valid
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result valid after reset.");

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_coordinate_valid) |-> (rsp_blurred_value == '0))
      else $error("Outside read returned a nonzero value.");

   a_write_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_action == ACTION_WRITE)) |=> !req_stall)
      else $error("Write transaction did not complete in one cycle.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_blurred_value)))
      else $error("Stalled result changed.");

endmodule

bind normalized_inverse_quadratic_blur_core niqb_checker u_niqb_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_action(req_action),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_blurred_value(rsp_blurred_value),
   .rsp_coordinate_valid(rsp_coordinate_valid)
);
`default_nettype wire

// ----- tb/normalized_inverse_quadratic_blur_core_tb.sv -----
// ---------------------------------------------------------------------------
// normalized_inverse_quadratic_blur_core_tb
// Self-checking bench for the blur core. A generator builds pixel writes and
// blurred reads, predicts each read from its own copy of the image and of
// the registers, and queues the transactions for a clocked driver. A clocked
// monitor compares every result with the oldest prediction. The run walks
// through several register settings and idle/stall patterns.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module normalized_inverse_quadratic_blur_core_tb;
   import niqb_pkg::*;

   typedef struct {
      logic             action;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] column;
      logic [PIX_W-1:0] pixel;
   } pixel_op_type;

   typedef struct {
      logic [PIX_W-1:0] value;
      logic             in_image;
   } blur_out_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_action;
   logic [ROW_W-1:0]  req_row;
   logic [COL_W-1:0]  req_column;
   logic [PIX_W-1:0]  req_pixel_in;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [PIX_W-1:0]  rsp_blurred_value;
   logic              rsp_coordinate_valid;
   logic              csr_write_enable;
   logic [1:0]        csr_index;
   logic [15:0]       csr_write_data;

   pixel_op_type  op_queue[$];
   blur_out_type  blur_queue[$];
   pixel_op_type  drv_op;
   blur_out_type  want;
   int         errors = 0;
   int         tx_pct = 0;
   int         rx_pct = 0;
   int         hold_token = 0;
   int         hold_seen = 0;
   int         hold_left = 0;

   logic [PIX_W-1:0] image_copy [DEPTH];
   bit               image_written [DEPTH];
   logic [9:0]       rows_reg;
   logic [9:0]       cols_reg;
   logic [3:0]       width_reg;
   logic [15:0]      amount_reg;

   normalized_inverse_quadratic_blur_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_row(req_row), .req_column(req_column), .req_pixel_in(req_pixel_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_blurred_value(rsp_blurred_value),
      .rsp_coordinate_valid(rsp_coordinate_valid),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (op_queue.size() > 0 && $urandom_range(99) >= tx_pct) begin
            drv_op = op_queue.pop_front();
            req_valid    <= 1'b1;
            req_action   <= drv_op.action;
            req_row      <= drv_op.row;
            req_column   <= drv_op.column;
            req_pixel_in <= drv_op.pixel;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = 600;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
      end
      rsp_stall <= (hold_left > 0) || ($urandom_range(99) < rx_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (blur_queue.size() == 0) begin
            $display("%0t: unexpected result value=%h valid=%b", $realtime,
                     rsp_blurred_value, rsp_coordinate_valid);
            errors++;
         end else begin
            want = blur_queue.pop_front();
            if (rsp_blurred_value !== want.value) begin
               $display("%0t: blurred_value expected %h actual %h", $realtime,
                        want.value, rsp_blurred_value);
               errors++;
            end
            if (rsp_coordinate_valid !== want.in_image) begin
               $display("%0t: coordinate_valid expected %b actual %b", $realtime,
                        want.in_image, rsp_coordinate_valid);
               errors++;
            end
         end
      end
   end

   function automatic int rows_eff();
      return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
   endfunction

   function automatic int cols_eff();
      return (cols_reg > MAX_COLUMNS) ? MAX_COLUMNS : int'(cols_reg);
   endfunction

   function automatic logic [63:0] tap_weight(logic [63:0] a2, logic [63:0] d2);
      logic [63:0] den;
      logic [63:0] w;
      if (d2 == 0) return 64'd65535;
      den = a2 + (d2 << 16);
      w = ((a2 << 16) + den / 2) / den;
      return (w > 64'd65535) ? 64'd65535 : w;
   endfunction

   function automatic blur_out_type blur_at(int r, int c);
      blur_out_type res;
      logic [63:0] a2;
      logic [63:0] sum;
      logic [63:0] total;
      logic [63:0] wt;
      logic [63:0] q;
      int          half;
      int          rr;
      int          cc;
      res.value = '0;
      res.in_image = 1'b0;
      if (r >= rows_eff() || c >= cols_eff()) return res;
      a2 = 64'(amount_reg) * 64'(amount_reg);
      half = int'(width_reg) / 2;
      sum = 0;
      total = 0;
      for (int di = -half; di <= half; di++) begin
         for (int dj = -half; dj <= half; dj++) begin
            rr = r + di;
            cc = c + dj;
            if (rr >= 0 && rr < rows_eff() && cc >= 0 && cc < cols_eff()) begin
               wt = tap_weight(a2, 64'(di * di + dj * dj));
               sum += 64'(image_copy[rr * MAX_COLUMNS + cc]) * wt;
               total += wt;
            end
         end
      end
      q = (sum + total / 2) / total;
      res.value = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
      res.in_image = 1'b1;
      return res;
   endfunction

   function automatic logic [31:0] rand_pixel();
      case ($urandom_range(4))
         0: return 32'hFFFF_FFFF;
         1: return 32'h0;
         2: return 32'($urandom_range(65535));
         default: return $urandom();
      endcase
   endfunction

   task automatic put_write(int r, int c, logic [31:0] p);
      pixel_op_type op;
      op.action = ACTION_WRITE;
      op.row = r[ROW_W-1:0];
      op.column = c[COL_W-1:0];
      op.pixel = p;
      op_queue.push_back(op);
      if (r < rows_eff() && c < cols_eff()) begin
         image_copy[r * MAX_COLUMNS + c] = p;
         image_written[r * MAX_COLUMNS + c] = 1'b1;
      end
   endtask

   task automatic put_read(int r, int c);
      pixel_op_type op;
      int        half;
      half = int'(width_reg) / 2;
      if (r < rows_eff() && c < cols_eff()) begin
         for (int rr = r - half; rr <= r + half; rr++)
            for (int cc = c - half; cc <= c + half; cc++)
               if (rr >= 0 && rr < rows_eff() && cc >= 0 && cc < cols_eff())
                  if (!image_written[rr * MAX_COLUMNS + cc])
                     put_write(rr, cc, rand_pixel());
      end
      op.action = ACTION_READ;
      op.row = r[ROW_W-1:0];
      op.column = c[COL_W-1:0];
      op.pixel = $urandom();
      op_queue.push_back(op);
      blur_queue.push_back(blur_at(r, c));
   endtask

   task automatic drain();
      do begin
         @(posedge clock);
         #1;
      end while (op_queue.size() > 0 || req_valid || blur_queue.size() > 0);
      repeat (64) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         REG_ROWS:    rows_reg = val[9:0];
         REG_COLUMNS: cols_reg = val[9:0];
         REG_WINDOW:  width_reg = val[3:0];
         default:     amount_reg = val;
      endcase
   endtask

   task automatic set_all(int r, int c, int w, int a);
      write_reg(REG_ROWS, 16'(r));
      write_reg(REG_COLUMNS, 16'(c));
      write_reg(REG_WINDOW, 16'(w));
      write_reg(REG_AMOUNT, 16'(a));
   endtask

   function automatic int pick_coord(int lim);
      if (lim > 0 && $urandom_range(99) < 85) return $urandom_range(lim - 1);
      return $urandom_range(511);
   endfunction

   task automatic random_phase(int count);
      int r;
      int c;
      int sel;
      int sz;
      sel = $urandom_range(9);
      sz = (sel < 2) ? 1023 : (sel < 4) ? 512 : $urandom_range(1, 24);
      r = sz;
      sz = (sel < 2) ? 512 : (sel < 4) ? 1023 : $urandom_range(1, 24);
      c = sz;
      set_all(r, c,
              (sel >= 4 && $urandom_range(9) == 0) ? 15 : $urandom_range(0, 3),
              ($urandom_range(3) == 0) ? 65535 : ($urandom_range(2) == 0) ? 1
                                       : $urandom_range(1, 65535));
      for (int k = 0; k < count; k++) begin
         sel = $urandom_range(99);
         r = pick_coord(rows_eff());
         c = pick_coord(cols_eff());
         if (sel < 45) put_write(r, c, rand_pixel());
         else if (sel < 55) put_write($urandom_range(511), $urandom_range(511), $urandom());
         else put_read(r, c);
      end
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACTION_WRITE;
      req_row = '0;
      req_column = '0;
      req_pixel_in = '0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = REG_ROWS;
      csr_write_data = '0;
      rows_reg = 10'd512;
      cols_reg = 10'd512;
      width_reg = 4'd3;
      amount_reg = 16'd256;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      put_write(0, 0, 32'hFFFF_FFFF);
      put_read(0, 0);
      put_write(511, 511, 32'h0);
      put_read(511, 511);
      put_read(200, 300);
      drain();
      set_all(1023, 1023, 15, 65535);
      put_read(0, 511);
      put_read(511, 0);
      drain();
      set_all(0, 5, 0, 0);
      put_write(0, 0, 32'h1234_5678);
      put_read(0, 0);
      drain();
      set_all(7, 9, 0, 0);
      put_read(6, 8);
      put_read(7, 3);
      put_read(2, 9);
      drain();
      write_reg(REG_WINDOW, 16'd4);
      put_read(3, 4);
      drain();
      write_reg(REG_AMOUNT, 16'd1);
      put_read(3, 4);
      put_write(8, 2, 32'hDEAD_BEEF);
      put_write(3, 4, 32'hFFFF_FFFF);
      put_read(3, 4);
      drain();

      tx_pct = 0;  rx_pct = 0;  random_phase(95);
      random_phase(95);
      tx_pct = 79; rx_pct = 0;  random_phase(95);
      random_phase(95);
      tx_pct = 0;  rx_pct = 79; random_phase(95);
      random_phase(95);
      tx_pct = 26; rx_pct = 26; random_phase(95);
      random_phase(95);

      tx_pct = 0;  rx_pct = 0;
      set_all(8, 8, 3, 256);
      hold_token++;
      for (int k = 0; k < 20; k++) put_read($urandom_range(7), $urandom_range(7));
      drain();

      repeat (200) @(posedge clock);
      if (errors == 0 && blur_queue.size() == 0) begin
         $display("normalized_inverse_quadratic_blur_core_tb passed");
      end else begin
         $display("normalized_inverse_quadratic_blur_core_tb failed");
      end
      $finish;
   end

   initial begin
      #80ms;
      $display("normalized_inverse_quadratic_blur_core_tb failed");
      $finish;
   end

endmodule
